// ----- rtl/prx_pkg.sv -----
`default_nettype none

package prx_pkg;

	// run and buffer sizing
	localparam int MAX_RUN   = 256;
	localparam int BUF_DEPTH = 64;
	localparam int THR_LIMIT = 64;
	localparam int THR_CAP   = (BUF_DEPTH < THR_LIMIT) ? BUF_DEPTH : THR_LIMIT;
	localparam int RUN_W     = $clog2(MAX_RUN + 1);
	localparam int ADDR_W    = $clog2(BUF_DEPTH);
	localparam int CFG_W     = 7;

	// character codes
	localparam logic [7:0] CHAR_TAB = 8'h09;
	localparam logic [7:0] CHAR_LF  = 8'h0A;
	localparam logic [7:0] CHAR_CR  = 8'h0D;
	localparam logic [7:0] CHAR_LO  = 8'h20;
	localparam logic [7:0] CHAR_HI  = 8'h7E;

	// input item kinds
	localparam logic KIND_DATA = 1'b0;
	localparam logic KIND_EOI  = 1'b1;

	localparam logic [CFG_W-1:0] MIN_RUN_RST = CFG_W'(4);

	typedef struct packed {
		logic       kind;
		logic [7:0] data_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last;
	} out_item_t;

	// controller states
	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_PASS = 6'b000010,
		ST_RD   = 6'b000100,
		ST_WR   = 6'b001000,
		ST_CR   = 6'b010000,
		ST_LF   = 6'b100000
	} state_t;

	// source of the byte loaded into the output register
	typedef enum logic [2:0] {
		EMIT_NONE = 3'd0,
		EMIT_BYTE = 3'd1,
		EMIT_MEM  = 3'd2,
		EMIT_CR   = 3'd3,
		EMIT_LF   = 3'd4
	} emit_sel_t;

	typedef struct packed {
		logic      grow;
		logic      start_drain;
		logic      clear_run;
		logic      latch;
		logic      rd;
		logic      next_idx;
		emit_sel_t emit;
	} cmd_t;

	typedef struct packed {
		logic printable;
		logic can_grow;
		logic passing;
		logic qualify;
		logic drain_last;
		logic out_free;
	} sts_t;

endpackage

`default_nettype wire

// ----- rtl/prx_datapath.sv -----
`default_nettype none

module prx_datapath import prx_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire in_item_t         src_item,
	input  wire logic             cfg_valid,
	input  wire logic [CFG_W-1:0] cfg_data,
	input  wire cmd_t             cmd,
	output sts_t                  sts,
	output logic                  dst_valid,
	input  wire logic             dst_stall,
	output out_item_t             dst_item
);

	logic [CFG_W-1:0]  min_run_q;
	logic [RUN_W-1:0]  run_len_q;
	logic              passing_q;
	logic [ADDR_W-1:0] idx_q;
	logic [7:0]        byte_q;
	logic [7:0]        rdata_q;
	logic              out_valid_q;
	out_item_t         out_q;
	logic [7:0]        mem [BUF_DEPTH];

	logic [CFG_W-1:0]  thr;
	logic              drain_last;
	logic              out_free;
	out_item_t         out_d;

	// effective threshold, clamped to 1..THR_CAP
	always_comb begin
		if (min_run_q == '0) begin
			thr = CFG_W'(1);
		end else if (min_run_q > CFG_W'(THR_CAP)) begin
			thr = CFG_W'(THR_CAP);
		end else begin
			thr = min_run_q;
		end
	end

	assign drain_last = (RUN_W'(idx_q) + RUN_W'(1)) == run_len_q;
	assign out_free   = !out_valid_q || !dst_stall;

	// status toward the controller
	always_comb begin
		sts.printable  = (src_item.kind == KIND_DATA) &&
			(((src_item.data_byte >= CHAR_LO) && (src_item.data_byte <= CHAR_HI)) ||
			(src_item.data_byte == CHAR_TAB));
		sts.can_grow   = run_len_q < RUN_W'(MAX_RUN);
		sts.passing    = passing_q;
		sts.qualify    = ((RUN_W + 1)'(run_len_q) + (RUN_W + 1)'(1)) >= (RUN_W + 1)'(thr);
		sts.drain_last = drain_last;
		sts.out_free   = out_free;
	end

	// output byte select
	always_comb begin
		case (cmd.emit)
			EMIT_BYTE: out_d = '{out_byte: byte_q,  last: 1'b1};
			EMIT_MEM:  out_d = '{out_byte: rdata_q, last: drain_last};
			EMIT_CR:   out_d = '{out_byte: CHAR_CR, last: 1'b0};
			EMIT_LF:   out_d = '{out_byte: CHAR_LF, last: 1'b1};
			default:   out_d = '{out_byte: 8'h00,   last: 1'b0};
		endcase
	end

	// run control state and configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_run_q   <= MIN_RUN_RST;
			run_len_q   <= '0;
			passing_q   <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				min_run_q <= cfg_data;
			end
			if (cmd.clear_run) begin
				run_len_q <= '0;
				passing_q <= 1'b0;
			end else if (cmd.grow) begin
				run_len_q <= run_len_q + RUN_W'(1);
			end
			if (cmd.start_drain) begin
				passing_q <= 1'b1;
				idx_q     <= '0;
			end else if (cmd.next_idx) begin
				idx_q <= idx_q + ADDR_W'(1);
			end
			if (cmd.emit != EMIT_NONE) begin
				out_valid_q <= 1'b1;
			end else if (!dst_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// run buffer, registered read
	always_ff @(posedge clk) begin
		if (cmd.grow && (run_len_q < RUN_W'(BUF_DEPTH))) begin
			mem[run_len_q[ADDR_W-1:0]] <= src_item.data_byte;
		end
		if (cmd.rd) begin
			rdata_q <= mem[idx_q];
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			byte_q <= src_item.data_byte;
		end
		if (cmd.emit != EMIT_NONE) begin
			out_q <= out_d;
		end
	end

	assign dst_valid = out_valid_q;
	assign dst_item  = out_q;

endmodule

`default_nettype wire

// ----- rtl/prx_ctrl.sv -----
`default_nettype none

module prx_ctrl import prx_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic src_valid,
	output logic      src_stall,
	input  wire sts_t sts,
	output cmd_t      cmd,
	output state_t    state
);

	state_t state_q;
	state_t state_d;

	assign src_stall = (state_q != ST_IDLE);
	assign state     = state_q;

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '{emit: EMIT_NONE, default: 1'b0};
		unique case (state_q)
			ST_IDLE: begin
				if (src_valid) begin
					if (sts.printable) begin
						if (sts.can_grow) begin
							cmd.grow = 1'b1;
							if (sts.passing) begin
								cmd.latch = 1'b1;
								state_d   = ST_PASS;
							end else if (sts.qualify) begin
								cmd.start_drain = 1'b1;
								state_d         = ST_RD;
							end
						end
					end else begin
						cmd.clear_run = 1'b1;
						if (sts.passing) begin
							state_d = ST_CR;
						end
					end
				end
			end
			ST_PASS: begin
				if (sts.out_free) begin
					cmd.emit = EMIT_BYTE;
					state_d  = ST_IDLE;
				end
			end
			ST_RD: begin
				cmd.rd  = 1'b1;
				state_d = ST_WR;
			end
			ST_WR: begin
				if (sts.out_free) begin
					cmd.emit = EMIT_MEM;
					if (sts.drain_last) begin
						state_d = ST_IDLE;
					end else begin
						cmd.next_idx = 1'b1;
						state_d      = ST_RD;
					end
				end
			end
			ST_CR: begin
				if (sts.out_free) begin
					cmd.emit = EMIT_CR;
					state_d  = ST_LF;
				end
			end
			ST_LF: begin
				if (sts.out_free) begin
					cmd.emit = EMIT_LF;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/printable_run_extractor_core.sv -----
// Printable run extractor: scans a byte stream and forwards runs of printable
// characters (0x20..0x7E, tab) reaching min_run bytes (clamped 1..64), each closed by CR LF.
// Input channel src_valid/src_stall/src_item carries one byte or an end-of-input
// marker; output channel dst_valid/dst_stall/dst_item carries one character per
// transfer, with last set on the final character caused by an input item.
// The cfg channel (cfg_valid/cfg_ready/cfg_data) writes min_run; it is always
// ready and should be used only while the block is idle.
// Sequencing: a pass-through byte is latched when it is taken and then loaded into
// the output register once that register is free. A run that just qualified drains
// its n buffered bytes (n <= 64) with one buffer read and then one output load per
// byte, as the run buffer has a single read port. A terminator after a reported
// run loads CR and then LF.
// While the output register holds a stalled character the controller waits, and
// src_stall stays high until the current item's characters are all loaded.
// Reset clears the run length, the reporting flag and the output valid flag and
// sets min_run to 4; buffer contents are not cleared, as entries are only read
// after being written within the current run.
`default_nettype none

module printable_run_extractor_core import prx_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             src_valid,
	output logic                  src_stall,
	input  wire in_item_t         src_item,
	output logic                  dst_valid,
	input  wire logic             dst_stall,
	output out_item_t             dst_item,
	input  wire logic             cfg_valid,
	output logic                  cfg_ready,
	input  wire logic [CFG_W-1:0] cfg_data
);

	cmd_t   cmd;
	sts_t   sts;
	state_t state;

	assign cfg_ready = 1'b1;

	// sequencer
	prx_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_stall (src_stall),
		.sts       (sts),
		.cmd       (cmd),
		.state     (state)
	);

	// run buffer, counters and output register
	prx_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_item  (src_item),
		.cfg_valid (cfg_valid && cfg_ready),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.sts       (sts),
		.dst_valid (dst_valid),
		.dst_stall (dst_stall),
		.dst_item  (dst_item)
	);

	// a character is never loaded over one still waiting to transfer
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit != EMIT_NONE) |-> sts.out_free)
		else $error("output register overwritten");

	// draining only happens for a run that is being reported
	a_drain_passing: assert property (@(posedge clk) disable iff (!arst_n)
		((state == ST_RD) || (state == ST_WR)) |-> sts.passing)
		else $error("buffer drain outside a reported run");

	// CR is always followed by LF as the next loaded character
	a_cr_then_lf: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit == EMIT_CR) |=> (state == ST_LF))
		else $error("CR not followed by LF");

endmodule

`default_nettype wire
